// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked on clk, disabled while rstn is low.
`define EBRE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ebre assertion failed");

// Condition that must never hold outside reset.
`define EBRE_NEVER(lbl, clk, rstn, cond) \
    `EBRE_ASSERT(lbl, clk, rstn, !(cond))

`endif

// File: rtl/ebre_pkg.sv
// Package for the escape-byte RLE encoder: types, constants, helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ebre_pkg;

    localparam logic [7:0] ESC_RESET     = 8'hED;
    localparam logic [7:0] MAX_RUN_RESET = 8'd240;
    localparam logic [7:0] MIN_RUN_RESET = 8'd4;
    localparam logic [7:0] LITERAL_LIMIT = 8'd4;
    localparam logic [7:0] END_CODE      = 8'h00;

    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_ESCAPE  = 2'd0,
        REG_MAX_RUN = 2'd1,
        REG_MIN_RUN = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] esc;
        logic [7:0] max_run;
        logic [7:0] min_run;
    } t_cfg;

    // One queued request: old run flush (a), final run flush (b) plus terminator.
    typedef struct packed {
        logic       a_en;
        logic       a_coded;
        logic [7:0] a_val;
        logic [7:0] a_len;
        logic       term;     // also enables the b flush
        logic       b_coded;
        logic [7:0] b_val;
        logic [7:0] b_len;
        logic [7:0] esc;
    } t_cmd;

    typedef enum logic [1:0] {
        SEG_A,
        SEG_B,
        SEG_TERM
    } t_seg;

    function automatic logic is_coded(input logic [7:0] val, input logic [7:0] len,
                                      input t_cfg cfg);
        logic [7:0] thr;
        thr = (cfg.min_run > LITERAL_LIMIT) ? LITERAL_LIMIT : cfg.min_run;
        return (len >= thr) || (val == cfg.esc);
    endfunction

endpackage

// File: rtl/ebre_fifo.sv
// Small flop-based request queue between the front and back parts.
// Depends on ebre_pkg (t_cmd).
`timescale 1ns / 1ps

module ebre_fifo import ebre_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_rdata
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// File: rtl/ebre_front.sv
// Front part: tracks the pending run and turns each input byte that ends a run or the stream into a flush request.
// Depends on ebre_pkg (t_cfg, t_cmd, is_coded).
`timescale 1ns / 1ps

module ebre_front import ebre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [7:0] r_run_val, n_run_val;
    logic [7:0] r_run_len, n_run_len;

    logic [7:0] cap;
    logic       extend;
    logic [7:0] new_val, new_len;

    assign cap    = (i_cfg.max_run == 8'd0) ? 8'd1 : i_cfg.max_run;
    assign extend = (r_run_len != 8'd0) && (i_data == r_run_val) && (r_run_len < cap);

    always_comb begin
        new_val = extend ? r_run_val : i_data;
        new_len = extend ? (r_run_len + 8'd1) : 8'd1;

        o_cmd.a_en    = !extend && (r_run_len != 8'd0);
        o_cmd.a_coded = is_coded(r_run_val, r_run_len, i_cfg);
        o_cmd.a_val   = r_run_val;
        o_cmd.a_len   = r_run_len;
        o_cmd.term    = i_last;
        o_cmd.b_coded = is_coded(new_val, new_len, i_cfg);
        o_cmd.b_val   = new_val;
        o_cmd.b_len   = new_len;
        o_cmd.esc     = i_cfg.esc;

        o_push = i_accept && (o_cmd.a_en || i_last);

        // end of stream clears the run
        n_run_val = i_last ? 8'd0 : new_val;
        n_run_len = i_last ? 8'd0 : new_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_val <= 8'd0;
            r_run_len <= 8'd0;
        end else if (i_accept) begin
            r_run_val <= n_run_val;
            r_run_len <= n_run_len;
        end
    end

endmodule

// File: rtl/ebre_back.sv
// Back part: walks a queued request byte by byte into a registered output stage.
// Depends on ebre_pkg (t_cmd, t_seg, END_CODE).
`timescale 1ns / 1ps

module ebre_back import ebre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last
);

    t_seg       r_seg, n_seg;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;

    t_seg       eff_seg;
    logic       seg_coded;
    logic [7:0] seg_val, seg_len;
    logic [1:0] seg_last_idx;
    logic       last_of_seg, last_of_cmd;
    logic       fire;
    logic [7:0] cur_byte;

    assign fire = i_q_valid && (!r_out_valid || i_ready);

    // Segment decode; a request without an old-run flush starts at the final run.
    always_comb begin
        eff_seg = (r_seg == SEG_A && !i_cmd.a_en) ? SEG_B : r_seg;
        seg_coded = (eff_seg == SEG_A) ? i_cmd.a_coded : i_cmd.b_coded;
        seg_val   = (eff_seg == SEG_A) ? i_cmd.a_val   : i_cmd.b_val;
        seg_len   = (eff_seg == SEG_A) ? i_cmd.a_len   : i_cmd.b_len;
        if (eff_seg == SEG_TERM) begin
            seg_last_idx = 2'd1;
        end else if (seg_coded) begin
            seg_last_idx = 2'd2;
        end else begin
            seg_last_idx = seg_len[1:0] - 2'd1;  // literal runs are 1 to 3 long
        end
        last_of_seg = (r_idx == seg_last_idx);
        last_of_cmd = last_of_seg && (eff_seg == SEG_TERM || (eff_seg == SEG_A && !i_cmd.term));
    end

    // Output byte select
    always_comb begin
        unique case (eff_seg)
            SEG_TERM: cur_byte = (r_idx == 2'd0) ? i_cmd.esc : END_CODE;
            default: begin
                if (!seg_coded) begin
                    cur_byte = seg_val;
                end else if (r_idx == 2'd0) begin
                    cur_byte = i_cmd.esc;
                end else if (r_idx == 2'd1) begin
                    cur_byte = seg_len;
                end else begin
                    cur_byte = seg_val;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_seg = r_seg;
        n_idx = r_idx;
        if (fire) begin
            if (last_of_cmd) begin
                n_seg = SEG_A;
                n_idx = 2'd0;
            end else if (last_of_seg) begin
                unique case (eff_seg)
                    SEG_A:   n_seg = SEG_B;
                    SEG_B:   n_seg = SEG_TERM;
                    default: n_seg = SEG_A;
                endcase
                n_idx = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    assign o_pop   = fire && last_of_cmd;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= SEG_A;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg <= n_seg;
            r_idx <= n_idx;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= cur_byte;
            r_out_last <= last_of_cmd;
        end
    end

endmodule

// File: rtl/escape_byte_rle_encoder.sv
// Escape-byte run-length encoder top level: config registers, front, queue, back.
// Depends on ebre_pkg, ebre_front, ebre_fifo, ebre_back.
`timescale 1ns / 1ps

// Takes one raw byte per input request and emits the compressed stream one code byte
// per cycle unless m_tready stalls it. Runs of equal bytes (up to max_run) are sent as
// the triple escape, count, value when long enough or when the value is the escape
// code, otherwise as literal copies; the byte flagged tlast flushes its run and adds
// escape, 0x00. m_tlast marks the last code byte caused by an input byte.
// Rate: the output side moves one code byte per cycle while a request is queued and
// m_tready is high; an input byte causes 0 to 8 code bytes, 3 for a run of escape
// bytes. The front takes a new byte every cycle while the request queue
// (QUEUE_DEPTH entries) has room, so runs that merely grow are absorbed at one byte
// per cycle. An accepted byte's request is registered in the queue, and its first
// code byte then in the output stage. No clearing pass after reset.
module escape_byte_rle_encoder import ebre_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4   // request queue entries, 2 or more
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] code_byte
    output logic              m_tlast,   // burst_end
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg r_cfg;
    t_cmd front_cmd, head_cmd;
    logic front_push, q_full, q_valid, q_pop;
    logic in_accept, cfg_wr;
    t_reg_idx reg_sel;

    // Register port: no wait states, always ready.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.esc     <= ESC_RESET;
            r_cfg.max_run <= MAX_RUN_RESET;
            r_cfg.min_run <= MIN_RUN_RESET;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (reg_sel)
                REG_ESCAPE:  r_cfg.esc     <= pwdata[7:0];
                REG_MAX_RUN: r_cfg.max_run <= pwdata[7:0];
                REG_MIN_RUN: r_cfg.min_run <= pwdata[7:0];
                default: ;   // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            unique case (reg_sel)
                REG_ESCAPE:  prdata = {24'd0, r_cfg.esc};
                REG_MAX_RUN: prdata = {24'd0, r_cfg.max_run};
                REG_MIN_RUN: prdata = {24'd0, r_cfg.min_run};
                default:     prdata = 32'd0;
            endcase
        end
    end

    // Front accepts whenever the queue can take a request.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    ebre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (in_accept),
        .i_data   (s_tdata),
        .i_last   (s_tlast),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    ebre_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (head_cmd)
    );

    ebre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_data    (m_tdata),
        .o_last    (m_tlast)
    );

endmodule

// File: rtl/ebre_checker.sv
// Port-level checker for the escape-byte RLE encoder, bound to the top level.
// Depends on ebre_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ebre_checker import ebre_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [7:0]        m_tdata,
    input logic              m_tlast,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // stalled output holds its byte
    `EBRE_ASSERT(a_out_hold, i_clk, i_rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `EBRE_NEVER(a_pready_low, i_clk, i_rst_n, !pready)
    // no code byte right out of reset
    `EBRE_ASSERT(a_reset_idle, i_clk, i_rst_n, $rose(i_rst_n) |-> !m_tvalid)
    // escape register reads back what was just written
    `EBRE_ASSERT(a_esc_readback, i_clk, i_rst_n,
        psel && penable && pwrite && paddr == 4'd0 |=>
            (paddr != 4'd0 || prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind escape_byte_rle_encoder ebre_checker u_ebre_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

// File: tb/tb.sv
// Testbench for escape_byte_rle_encoder: directed and random byte streams
// checked against a behavioral encoder model. Depends on ebre_pkg and the RTL.
`timescale 1ns / 1ps

module tb import ebre_pkg::*; ();

    localparam int CLK_HALF     = 10;       // 20 ns period
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 16;       // front latency plus queue depth, with margin
    localparam int CYCLE_LIMIT  = 200000;   // several times the slowest legal run

    // one code byte on the output stream
    typedef struct {
        logic [7:0] code;
        logic       burst_end;
    } t_code_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'h00;   // [7:0] data_byte
    logic              s_tlast = 1'b0;    // last_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;           // [7:0] code_byte
    logic              m_tlast;           // burst_end
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // encoder model state and its copy of the registers
    logic [7:0] esc_cfg     = ESC_RESET;
    logic [7:0] max_run_cfg = MAX_RUN_RESET;
    logic [7:0] min_run_cfg = MIN_RUN_RESET;
    logic [7:0] run_val     = 8'h00;
    logic [7:0] run_len     = 8'h00;

    t_code_beat code_q[$];      // code bytes still owed by the encoder
    t_code_beat burst_beats[$]; // code bytes of the request being modeled
    t_code_beat got_beat;

    int err_count = 0;
    int cycle_cnt = 0;

    // sender burst shaping and receiver stall shaping
    int burst_left = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    escape_byte_rle_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: watchdog expired, %0d code bytes still owed", $time,
                     code_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, stall_pct = 0 means never stall
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 6);
        end
    end

    // output checker: every accepted code byte against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected code byte: expected none, got code %02h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                got_beat = code_q.pop_front();
                if (m_tdata !== got_beat.code) begin
                    err_count++;
                    $display("%0t ns: code_byte mismatch: expected %02h, got %02h",
                             $time, got_beat.code, m_tdata);
                end
                if (m_tlast !== got_beat.burst_end) begin
                    err_count++;
                    $display("%0t ns: burst_end mismatch: expected %b, got %b",
                             $time, got_beat.burst_end, m_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Encoder model
    // ---------------------------------------------------------------
    function automatic void emit_code(input logic [7:0] code);
        t_code_beat beat;
        beat.code      = code;
        beat.burst_end = 1'b0;
        burst_beats.push_back(beat);
    endfunction

    // Flush the pending run as a triple or as literal copies.
    function automatic void flush_run();
        logic [7:0] thr;
        thr = (min_run_cfg > LITERAL_LIMIT) ? LITERAL_LIMIT : min_run_cfg;
        if (run_len != 8'd0) begin
            if (run_len >= thr || run_val == esc_cfg) begin
                emit_code(esc_cfg);
                emit_code(run_len);
                emit_code(run_val);
            end else begin
                for (int i = 0; i < run_len; i++)
                    emit_code(run_val);
            end
            run_len = 8'd0;
        end
    endfunction

    // Model one accepted input byte; owed code bytes go to code_q.
    function automatic void encode_byte(input logic [7:0] data, input logic last);
        logic [7:0] cap;
        cap = (max_run_cfg == 8'd0) ? 8'd1 : max_run_cfg;
        burst_beats.delete();
        if (run_len != 8'd0 && data == run_val && run_len < cap) begin
            run_len = run_len + 8'd1;
        end else begin
            flush_run();
            run_val = data;
            run_len = 8'd1;
        end
        if (last) begin
            // end of stream: flush, terminator, fresh stream state
            flush_run();
            emit_code(esc_cfg);
            emit_code(END_CODE);
            run_val = 8'h00;
            run_len = 8'h00;
        end
        if (burst_beats.size() != 0)
            burst_beats[burst_beats.size() - 1].burst_end = 1'b1;
        foreach (burst_beats[i])
            code_q.push_back(burst_beats[i]);
    endfunction

    // ---------------------------------------------------------------
    // Drivers; every task starts and ends just after a falling edge
    // ---------------------------------------------------------------

    // One input request. tvalid stays high across back-to-back requests
    // and only drops at the start of a gap between bursts.
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        encode_byte(data, last);
        @(negedge i_clk);
    endtask

    // Register write: setup phase, access phase until pready, then idle.
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom_range(0, 16777215)), value};  // upper bits are don't-care
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ESCAPE:  esc_cfg     = value;
            REG_MAX_RUN: max_run_cfg = value;
            REG_MIN_RUN: min_run_cfg = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending and let every owed code byte drain, then let requests
    // that caused no output clear the front end.
    task automatic drain_stream();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (code_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_run(input logic [7:0] data, input int count, input logic last);
        for (int i = 0; i < count; i++)
            send_byte(data, last && (i == count - 1));
    endtask

    task automatic write_config(input logic [7:0] esc, input logic [7:0] max_run,
                                input logic [7:0] min_run);
        drain_stream();
        write_reg(REG_ESCAPE, esc);
        write_reg(REG_MAX_RUN, max_run);
        write_reg(REG_MIN_RUN, min_run);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values: coded run, lone escape byte, literals, and the worst
    // case of three literals plus an escape triple plus terminator.
    task automatic test_reset_defaults();
        gap_max   = 0;
        stall_pct = 0;
        send_run(8'h42, 4, 1'b0);
        send_run(8'hED, 1, 1'b0);
        send_run(8'hFF, 1, 1'b0);
        send_run(8'h41, 3, 1'b0);
        send_run(8'hED, 1, 1'b1);
    endtask

    // Run cap splits; zero cap acts as one.
    task automatic test_run_cap();
        gap_max   = 3;
        stall_pct = 30;
        write_config(8'hED, 8'd3, 8'd2);
        send_run(8'h5A, 7, 1'b1);          // splits 3, 3, 1
        write_config(8'hED, 8'd0, 8'd2);
        send_run(8'h33, 2, 1'b1);
    endtask

    // Threshold zero codes everything; huge threshold saturates at four.
    // Escape code of zero makes the terminator two zero bytes.
    task automatic test_threshold_and_escape();
        gap_max   = 2;
        stall_pct = 50;
        write_config(8'hED, 8'd240, 8'd0);
        send_run(8'h10, 1, 1'b1);
        write_config(8'hED, 8'd240, 8'd255);
        send_run(8'h20, 3, 1'b0);
        send_run(8'h21, 1, 1'b1);
        write_config(8'h00, 8'd240, 8'd4);
        send_run(8'h00, 2, 1'b1);
    endtask

    // Long run past 128 so the count byte uses its top bit, then a split.
    task automatic test_long_run();
        gap_max   = 0;
        stall_pct = 10;
        write_config(8'hFF, 8'd130, 8'd1);
        send_run(8'h80, 133, 1'b1);
    endtask

    // Random streams: mostly runs of random value and length, some noise.
    task automatic test_random_streams(input int n_items);
        int         sent;
        int         len;
        int         cap;
        logic [7:0] val;
        logic [7:0] prev;
        logic       last;
        sent = 0;
        prev = 8'h00;
        cap  = (max_run_cfg == 8'd0) ? 1 : ((max_run_cfg > 12) ? 12 : max_run_cfg);
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: lone random byte, random last
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                case ($urandom_range(0, 7))
                    0, 1:    val = esc_cfg;
                    2:       val = prev;
                    3:       val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: val = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(1, cap + 2);
                    2:       len = 1;
                    default: len = $urandom_range(1, 5);
                endcase
                last = ($urandom_range(0, 5) == 0);
                send_run(val, len, last);
                prev = val;
                sent += len;
            end
        end
    endtask

    // Random register setting with the extremes weighted in.
    task automatic randomize_config();
        logic [7:0] esc;
        logic [7:0] max_run;
        logic [7:0] min_run;
        case ($urandom_range(0, 3))
            0:       esc = 8'h00;
            1:       esc = 8'hFF;
            default: esc = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0:       max_run = 8'd0;
            1:       max_run = 8'd1;
            2:       max_run = 8'd255;
            default: max_run = 8'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
            0:       min_run = 8'd0;
            1:       min_run = 8'd255;
            default: min_run = 8'($urandom_range(1, 5));
        endcase
        write_config(esc, max_run, min_run);
    endtask

    task automatic test_random_phases();
        // first phase at reset values without idling, then random settings
        write_config(ESC_RESET, MAX_RUN_RESET, MIN_RUN_RESET);
        gap_max   = 0;
        stall_pct = 0;
        test_random_streams(55);
        for (int phase = 0; phase < 4; phase++) begin
            randomize_config();
            gap_max   = $urandom_range(0, 6);
            stall_pct = $urandom_range(0, 60);
            test_random_streams(55);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_run_cap();
        test_threshold_and_escape();
        test_long_run();
        test_random_phases();

        drain_stream();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ebre_pkg.sv
rtl/ebre_fifo.sv
rtl/ebre_front.sv
rtl/ebre_back.sv
rtl/escape_byte_rle_encoder.sv
rtl/ebre_checker.sv
tb/tb.sv
